// ===== sv/rrbpc_pkg.sv =====
// Shared types and constants for the rounded-rectangle border pixel classifier.
// Holds the register map, reset values, pixel class codes and the stage structs.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package rrbpc_pkg;

	localparam int POS_BITS       = 13;
	localparam int SIZE_BITS      = 12;
	localparam int RAD_BITS       = 11;
	localparam int RSQ_BITS       = 2 * RAD_BITS;
	localparam int COLOR_BITS     = 32;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CLASS_BITS     = 2;

	// Corner offsets are clamped to +/-OFS_MAX; any clamped offset already lies
	// well beyond the largest radius, also after a one-pixel neighbor shift.
	localparam int OFS_BITS  = 13;
	localparam int OFS_MAX   = 4095;
	localparam int MAG_BITS  = 12;
	localparam int SQ_BITS   = 2 * MAG_BITS;
	localparam int TERM_BITS = SQ_BITS + 1;

	localparam logic signed [POS_BITS-1:0] RST_CARD_LEFT    = 13'sd750;
	localparam logic signed [POS_BITS-1:0] RST_CARD_TOP     = 13'sd420;
	localparam logic [SIZE_BITS-1:0]       RST_CARD_WIDTH   = 12'd420;
	localparam logic [SIZE_BITS-1:0]       RST_CARD_HEIGHT  = 12'd240;
	localparam logic [RAD_BITS-1:0]        RST_RADIUS       = 11'd16;
	localparam logic [RSQ_BITS-1:0]        RST_RADIUS_SQ    = 22'd256;
	localparam logic [COLOR_BITS-1:0]      RST_FILL_COLOR   = 32'hFF0F172A;
	localparam logic [COLOR_BITS-1:0]      RST_BORDER_COLOR = 32'hFF334155;
	localparam logic [COLOR_BITS-1:0]      RST_BG_COLOR     = 32'hFF0B1120;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CARD_LEFT        = 3'd0,
		REG_CARD_TOP         = 3'd1,
		REG_CARD_WIDTH       = 3'd2,
		REG_CARD_HEIGHT      = 3'd3,
		REG_CORNER_RADIUS    = 3'd4,
		REG_FILL_COLOR       = 3'd5,
		REG_BORDER_COLOR     = 3'd6,
		REG_BACKGROUND_COLOR = 3'd7
	} cfg_index_t;

	typedef enum logic [CLASS_BITS-1:0] {
		CLASS_BACKGROUND = 2'd0,
		CLASS_FILL       = 2'd1,
		CLASS_BORDER     = 2'd2
	} pixel_class_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] card_left;
		logic signed [POS_BITS-1:0] card_top;
		logic [SIZE_BITS-1:0]       card_width;
		logic [SIZE_BITS-1:0]       card_height;
		logic [RAD_BITS-1:0]        corner_radius;
		logic [RSQ_BITS-1:0]        radius_sq;
		logic [COLOR_BITS-1:0]      fill_color;
		logic [COLOR_BITS-1:0]      border_color;
		logic [COLOR_BITS-1:0]      background_color;
	} cfg_t;

	// Offsets of the pixel from the four corner circle centers, plus box flags.
	typedef struct packed {
		logic signed [OFS_BITS-1:0] ofs_left;
		logic signed [OFS_BITS-1:0] ofs_right;
		logic signed [OFS_BITS-1:0] ofs_top;
		logic signed [OFS_BITS-1:0] ofs_bottom;
		logic                       in_box;
		logic                       on_edge;
	} ofs_t;

	typedef struct packed {
		ofs_t                 ofs;
		logic [SQ_BITS-1:0]   sq_left;
		logic [SQ_BITS-1:0]   sq_right;
		logic [SQ_BITS-1:0]   sq_top;
		logic [SQ_BITS-1:0]   sq_bottom;
	} sq_t;

endpackage

// ===== sv/rrbpc_cfg_regs.sv =====
// Configuration register file of the card classifier, with the squared radius.
// Depends on rrbpc_pkg for the register map, widths and reset values.
`timescale 1ns / 1ps

module rrbpc_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [rrbpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [rrbpc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output rrbpc_pkg::cfg_t                       cfg
);
	import rrbpc_pkg::*;

	cfg_t                 cfg_q;
	logic [RSQ_BITS-1:0]  wr_radius_ext;
	logic [RSQ_BITS-1:0]  wr_radius_sq;

	// Square the radius at write time so the datapath only compares.
	assign wr_radius_ext = RSQ_BITS'(cfg_data[RAD_BITS-1:0]);
	assign wr_radius_sq  = wr_radius_ext * wr_radius_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				card_left:        RST_CARD_LEFT,
				card_top:         RST_CARD_TOP,
				card_width:       RST_CARD_WIDTH,
				card_height:      RST_CARD_HEIGHT,
				corner_radius:    RST_RADIUS,
				radius_sq:        RST_RADIUS_SQ,
				fill_color:       RST_FILL_COLOR,
				border_color:     RST_BORDER_COLOR,
				background_color: RST_BG_COLOR
			};
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				REG_CARD_LEFT:        cfg_q.card_left        <= cfg_data[POS_BITS-1:0];
				REG_CARD_TOP:         cfg_q.card_top         <= cfg_data[POS_BITS-1:0];
				REG_CARD_WIDTH:       cfg_q.card_width       <= cfg_data[SIZE_BITS-1:0];
				REG_CARD_HEIGHT:      cfg_q.card_height      <= cfg_data[SIZE_BITS-1:0];
				REG_CORNER_RADIUS: begin
					cfg_q.corner_radius <= cfg_data[RAD_BITS-1:0];
					cfg_q.radius_sq     <= wr_radius_sq;
				end
				REG_FILL_COLOR:       cfg_q.fill_color       <= cfg_data[COLOR_BITS-1:0];
				REG_BORDER_COLOR:     cfg_q.border_color     <= cfg_data[COLOR_BITS-1:0];
				REG_BACKGROUND_COLOR: cfg_q.background_color <= cfg_data[COLOR_BITS-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/rrbpc_offset_stage.sv =====
// First datapath stage: box test, edge test and clamped offsets to the corner centers.
// Depends on rrbpc_pkg for cfg_t, ofs_t and the offset widths.
`timescale 1ns / 1ps

module rrbpc_offset_stage #(
	parameter int COORD_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [COORD_BITS-1:0]  pixel_x,
	input  logic [COORD_BITS-1:0]  pixel_y,
	input  rrbpc_pkg::cfg_t        cfg,
	output logic                   valid_s2,
	output rrbpc_pkg::ofs_t        ofs_s2
);
	import rrbpc_pkg::*;

	localparam int SW = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 3;
	localparam logic signed [SW-1:0] SAT_HI = SW'(OFS_MAX);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI;

	function automatic logic signed [OFS_BITS-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [OFS_BITS-1:0] r;
		if (v > SAT_HI)
			r = OFS_BITS'(SAT_HI);
		else if (v < SAT_LO)
			r = OFS_BITS'(SAT_LO);
		else
			r = v[OFS_BITS-1:0];
		return r;
	endfunction

	logic signed [SW-1:0] px, py;
	logic signed [SW-1:0] left, top, width_s, height_s, rad;
	logic signed [SW-1:0] wm1, hm1, wrm1, hrm1;
	logic signed [SW-1:0] xl, yt;
	ofs_t                 ofs_d;

	assign px       = signed'(SW'(pixel_x));
	assign py       = signed'(SW'(pixel_y));
	assign left     = {{(SW-POS_BITS){cfg.card_left[POS_BITS-1]}}, cfg.card_left};
	assign top      = {{(SW-POS_BITS){cfg.card_top[POS_BITS-1]}}, cfg.card_top};
	assign width_s  = signed'(SW'(cfg.card_width));
	assign height_s = signed'(SW'(cfg.card_height));
	assign rad      = signed'(SW'(cfg.corner_radius));

	// Card-relative coordinates; the far corner centers sit at size-1-radius.
	assign wm1  = width_s - SW'(1);
	assign hm1  = height_s - SW'(1);
	assign wrm1 = wm1 - rad;
	assign hrm1 = hm1 - rad;
	assign xl   = px - left;
	assign yt   = py - top;

	always_comb begin
		ofs_d.in_box     = (xl >= 0) && (xl <= wm1) && (yt >= 0) && (yt <= hm1);
		ofs_d.on_edge    = (xl == 0) || (xl == wm1) || (yt == 0) || (yt == hm1);
		ofs_d.ofs_left   = sat(xl - rad);
		ofs_d.ofs_right  = sat(xl - wrm1);
		ofs_d.ofs_top    = sat(yt - rad);
		ofs_d.ofs_bottom = sat(yt - hrm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			ofs_s2 <= ofs_d;
		end
	end

endmodule

// ===== sv/rrbpc_square_stage.sv =====
// Second datapath stage: squares the four clamped corner offsets.
// Depends on rrbpc_pkg for ofs_t, sq_t and the magnitude widths.
`timescale 1ns / 1ps

module rrbpc_square_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	input  rrbpc_pkg::ofs_t  ofs_s2,
	output logic             valid_s3,
	output rrbpc_pkg::sq_t   sq_s3
);
	import rrbpc_pkg::*;

	function automatic logic [SQ_BITS-1:0] square(input logic signed [OFS_BITS-1:0] v);
		logic [OFS_BITS-1:0] mag;
		logic [SQ_BITS-1:0]  m;
		mag = v[OFS_BITS-1] ? OFS_BITS'(-v) : OFS_BITS'(v);
		m   = SQ_BITS'(mag[MAG_BITS-1:0]);
		return m * m;
	endfunction

	sq_t sq_d;

	always_comb begin
		sq_d.ofs       = ofs_s2;
		sq_d.sq_left   = square(ofs_s2.ofs_left);
		sq_d.sq_right  = square(ofs_s2.ofs_right);
		sq_d.sq_top    = square(ofs_s2.ofs_top);
		sq_d.sq_bottom = square(ofs_s2.ofs_bottom);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			sq_s3 <= sq_d;
		end
	end

endmodule

// ===== sv/rrbpc_classify_stage.sv =====
// Last datapath stage: corner tests for the pixel and its four neighbors, class and color.
// Depends on rrbpc_pkg for sq_t, cfg_t, pixel_class_t and the term widths.
`timescale 1ns / 1ps

module rrbpc_classify_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s3,
	input  rrbpc_pkg::sq_t                     sq_s3,
	input  rrbpc_pkg::cfg_t                    cfg,
	output logic                               done,
	output logic [rrbpc_pkg::COLOR_BITS-1:0]   pixel_color,
	output logic [rrbpc_pkg::CLASS_BITS-1:0]   pixel_class
);
	import rrbpc_pkg::*;

	// Neighbor shift along one axis: minus one, none, plus one.
	localparam logic [1:0] OFF_MINUS = 2'd0;
	localparam logic [1:0] OFF_NONE  = 2'd1;
	localparam logic [1:0] OFF_PLUS  = 2'd2;

	// (v+k)^2 from v^2: add or subtract 2v, then add one.
	function automatic logic [TERM_BITS-1:0] shifted_sq(
		input logic [SQ_BITS-1:0]         sq,
		input logic signed [OFS_BITS-1:0] v,
		input logic [1:0]                 k
	);
		logic signed [TERM_BITS:0] base;
		logic signed [TERM_BITS:0] twice;
		logic signed [TERM_BITS:0] t;
		base  = signed'({2'b00, sq});
		twice = signed'({{(TERM_BITS-OFS_BITS){v[OFS_BITS-1]}}, v, 1'b0});
		case (k)
			OFF_MINUS: t = base - twice + (TERM_BITS+1)'(1);
			OFF_PLUS:  t = base + twice + (TERM_BITS+1)'(1);
			default:   t = base;
		endcase
		return t[TERM_BITS-1:0];
	endfunction

	// v+k < 0
	function automatic logic below(input logic signed [OFS_BITS-1:0] v, input logic [1:0] k);
		logic r;
		case (k)
			OFF_MINUS: r = (v <= 0);
			OFF_PLUS:  r = (v < -1);
			default:   r = (v < 0);
		endcase
		return r;
	endfunction

	// v+k > 0
	function automatic logic above(input logic signed [OFS_BITS-1:0] v, input logic [1:0] k);
		logic r;
		case (k)
			OFF_MINUS: r = (v > 1);
			OFF_PLUS:  r = (v >= 0);
			default:   r = (v > 0);
		endcase
		return r;
	endfunction

	// First matching corner region decides; outside all regions never counts.
	function automatic logic beyond(
		input logic                 lx,
		input logic                 rx,
		input logic                 ty,
		input logic                 by,
		input logic [TERM_BITS-1:0] sl,
		input logic [TERM_BITS-1:0] sr,
		input logic [TERM_BITS-1:0] st,
		input logic [TERM_BITS-1:0] sb,
		input logic [RSQ_BITS-1:0]  rsq
	);
		logic [TERM_BITS-1:0] sx;
		logic [TERM_BITS-1:0] sy;
		logic                 hit;
		logic [TERM_BITS:0]   sum;
		hit = 1'b1;
		sx  = sl;
		sy  = st;
		if (lx && ty) begin
			sx = sl;
			sy = st;
		end else if (rx && ty) begin
			sx = sr;
			sy = st;
		end else if (lx && by) begin
			sx = sl;
			sy = sb;
		end else if (rx && by) begin
			sx = sr;
			sy = sb;
		end else begin
			hit = 1'b0;
		end
		sum = {1'b0, sx} + {1'b0, sy};
		return hit && (sum > (TERM_BITS+1)'(rsq));
	endfunction

	logic [TERM_BITS-1:0] tl [3];
	logic [TERM_BITS-1:0] tr [3];
	logic [TERM_BITS-1:0] tt [3];
	logic [TERM_BITS-1:0] tb [3];
	logic                 fl [3];
	logic                 fr [3];
	logic                 ft [3];
	logic                 fb [3];
	logic                 out_self, out_west, out_east, out_north, out_south;
	logic [COLOR_BITS-1:0] color_d;
	pixel_class_t          class_d;
	logic                  done_q;
	logic [COLOR_BITS-1:0] color_q;
	logic [CLASS_BITS-1:0] class_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tl[i] = shifted_sq(sq_s3.sq_left, sq_s3.ofs.ofs_left, 2'(i));
			tr[i] = shifted_sq(sq_s3.sq_right, sq_s3.ofs.ofs_right, 2'(i));
			tt[i] = shifted_sq(sq_s3.sq_top, sq_s3.ofs.ofs_top, 2'(i));
			tb[i] = shifted_sq(sq_s3.sq_bottom, sq_s3.ofs.ofs_bottom, 2'(i));
			fl[i] = below(sq_s3.ofs.ofs_left, 2'(i));
			fr[i] = above(sq_s3.ofs.ofs_right, 2'(i));
			ft[i] = below(sq_s3.ofs.ofs_top, 2'(i));
			fb[i] = above(sq_s3.ofs.ofs_bottom, 2'(i));
		end
	end

	assign out_self  = beyond(fl[OFF_NONE], fr[OFF_NONE], ft[OFF_NONE], fb[OFF_NONE],
		tl[OFF_NONE], tr[OFF_NONE], tt[OFF_NONE], tb[OFF_NONE], cfg.radius_sq);
	assign out_west  = beyond(fl[OFF_MINUS], fr[OFF_MINUS], ft[OFF_NONE], fb[OFF_NONE],
		tl[OFF_MINUS], tr[OFF_MINUS], tt[OFF_NONE], tb[OFF_NONE], cfg.radius_sq);
	assign out_east  = beyond(fl[OFF_PLUS], fr[OFF_PLUS], ft[OFF_NONE], fb[OFF_NONE],
		tl[OFF_PLUS], tr[OFF_PLUS], tt[OFF_NONE], tb[OFF_NONE], cfg.radius_sq);
	assign out_north = beyond(fl[OFF_NONE], fr[OFF_NONE], ft[OFF_MINUS], fb[OFF_MINUS],
		tl[OFF_NONE], tr[OFF_NONE], tt[OFF_MINUS], tb[OFF_MINUS], cfg.radius_sq);
	assign out_south = beyond(fl[OFF_NONE], fr[OFF_NONE], ft[OFF_PLUS], fb[OFF_PLUS],
		tl[OFF_NONE], tr[OFF_NONE], tt[OFF_PLUS], tb[OFF_PLUS], cfg.radius_sq);

	always_comb begin
		if (!sq_s3.ofs.in_box || out_self) begin
			class_d = CLASS_BACKGROUND;
			color_d = cfg.background_color;
		end else if (sq_s3.ofs.on_edge || out_west || out_east || out_north || out_south) begin
			class_d = CLASS_BORDER;
			color_d = cfg.border_color;
		end else begin
			class_d = CLASS_FILL;
			color_d = cfg.fill_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			color_q <= color_d;
			class_q <= class_d;
		end
	end

	assign done        = done_q;
	assign pixel_color = color_q;
	assign pixel_class = class_q;

endmodule

// ===== sv/rounded_rect_border_pixel_classifier.sv =====
// Pipeline: the 4 register ranks are input, offsets, squares and result; done rises
// once a pixel taken on start has passed through all of them, and falls again unless
// another one follows. One pixel every cycle; busy stays low, so start may be held high.
// Reset (arst_n low, asynchronous): pipeline valids clear, registers take their
// documented values; the result strobe cannot be held off by the receiver.
// Top level of the rounded-rectangle card classifier; uses rrbpc_pkg and the
// rrbpc_cfg_regs, rrbpc_offset_stage, rrbpc_square_stage, rrbpc_classify_stage modules.
`timescale 1ns / 1ps

module rounded_rect_border_pixel_classifier #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [COORD_BITS-1:0]                pixel_x,
	input  logic [COORD_BITS-1:0]                pixel_y,
	input  logic                                 cfg_write,
	input  logic [rrbpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rrbpc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                                 done,
	output logic [rrbpc_pkg::COLOR_BITS-1:0]     pixel_color,
	output logic [rrbpc_pkg::CLASS_BITS-1:0]     pixel_class
);
	import rrbpc_pkg::*;

	cfg_t                   cfg;
	logic                   accept;
	logic                   valid_s1;
	logic [COORD_BITS-1:0]  x_s1;
	logic [COORD_BITS-1:0]  y_s1;
	logic                   valid_s2;
	ofs_t                   ofs_s2;
	logic                   valid_s3;
	sq_t                    sq_s3;

	// Every stage advances each cycle; nothing ever backs up into the input.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	rrbpc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input rank: hold the coordinates of each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
	end

	// Box and edge flags, then clamped offsets from the four corner centers.
	rrbpc_offset_stage #(
		.COORD_BITS (COORD_BITS)
	) u_offset_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.pixel_x  (x_s1),
		.pixel_y  (y_s1),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.ofs_s2   (ofs_s2)
	);

	// One squarer per corner axis; neighbor squares are derived from these.
	rrbpc_square_stage u_square_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ofs_s2   (ofs_s2),
		.valid_s3 (valid_s3),
		.sq_s3    (sq_s3)
	);

	// Corner tests for the pixel and its four neighbors drive the result rank.
	rrbpc_classify_stage u_classify_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.sq_s3       (sq_s3),
		.cfg         (cfg),
		.done        (done),
		.pixel_color (pixel_color),
		.pixel_class (pixel_class)
	);

endmodule

// ===== sv/rrbpc_checker.sv =====
// Port-level checks for the card classifier, bound to its top level.
// Depends on rrbpc_pkg for port widths only.
`timescale 1ns / 1ps

module rrbpc_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic [COORD_BITS-1:0]                pixel_x,
	input logic [COORD_BITS-1:0]                pixel_y,
	input logic                                 cfg_write,
	input logic                                 done,
	input logic [rrbpc_pkg::COLOR_BITS-1:0]     pixel_color,
	input logic [rrbpc_pkg::CLASS_BITS-1:0]     pixel_class
);
	localparam logic [2:0] AGE_FULL   = 3'd4;
	localparam logic [2:0] QUIET_FULL = 3'd7;

	logic [2:0] rst_age_q;
	logic [2:0] quiet_q;
	logic       seen_q;

	// Cycles since reset release, and since the last register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_age_q <= '0;
			quiet_q   <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (rst_age_q != AGE_FULL)
				rst_age_q <= rst_age_q + 3'd1;
			if (cfg_write)
				quiet_q <= '0;
			else if (quiet_q != QUIET_FULL)
				quiet_q <= quiet_q + 3'd1;
			if (done)
				seen_q <= 1'b1;
		end
	end

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(rst_age_q == AGE_FULL) |-> (done == $past(start && !busy, 4)))
		else $error("result strobe does not follow accepted transaction by 4 cycles");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q && !done) |-> ($stable(pixel_color) && $stable(pixel_class)))
		else $error("result changed without a strobe");

	a_same_pixel_same_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && (quiet_q == QUIET_FULL) &&
		 ($past(pixel_x, 4) == $past(pixel_x, 5)) &&
		 ($past(pixel_y, 4) == $past(pixel_y, 5)))
		|-> ((pixel_color == $past(pixel_color)) && (pixel_class == $past(pixel_class))))
		else $error("repeated pixel gave a different result");

endmodule

bind rounded_rect_border_pixel_classifier rrbpc_checker #(
	.COORD_BITS (COORD_BITS)
) u_rrbpc_checker (.*);
